@@ design/cubemap_bilinear_sampler_assert.svh @@
// ----------------------------------------------------------------------------
// Cube map sampler assertion macros
// Shared property forms for the sampler's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CUBEMAP_BILINEAR_SAMPLER_ASSERT_SVH
`define CUBEMAP_BILINEAR_SAMPLER_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define CBS_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define CBS_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ design/cbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Cube map sampler package
// Widths, codes, constants and pipeline types shared by the sampler modules.
// ----------------------------------------------------------------------------
package cbs_pkg;

    localparam int MAX_FACE_SIZE = 64;
    localparam int FACE_COUNT    = 6;

    localparam int FS_W     = $clog2(MAX_FACE_SIZE);
    localparam int HALF_W   = FS_W - 1;
    localparam int FACE_W   = 3;
    localparam int POS_W    = 6;
    localparam int DIR_W    = 16;
    localparam int CH_W     = 16;
    localparam int TEXEL_W  = 3 * CH_W;
    localparam int FRAC_W   = 16;

    // Divider: divisor is 2*ma, quotient is the face position in Q.16.
    localparam int DV_W       = DIR_W + 1;
    localparam int QT_W       = FS_W + FRAC_W;
    localparam int NUM_W      = DV_W + QT_W;
    localparam int DIV_STAGES = QT_W;

    localparam int RAM_AW    = FACE_W + 2 * HALF_W;
    localparam int RAM_DEPTH = FACE_COUNT * (MAX_FACE_SIZE / 2) * (MAX_FACE_SIZE / 2);
    localparam int BANKS     = 4;

    localparam int WGT_W    = 2 * FRAC_W + 1;
    localparam int PROD_W   = CH_W + WGT_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int ROUND_SH = 2 * FRAC_W;

    localparam int CFG_W  = 7;
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] REG_FACE_SIZE = 1'd0;
    localparam logic [CFG_AW-1:0] REG_SKY_VALID = 1'd1;
    localparam logic [CFG_W-1:0]  FACE_SIZE_RST = 7'd64;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Sky gradient as exact integer forms of the scaled rational values.
    localparam int SKY_R_MUL   = 384;
    localparam int SKY_R_ADD   = 19038208;
    localparam int SKY_R_RECIP = 13108;
    localparam int SKY_G_MUL   = 2304;
    localparam int SKY_G_ADD   = 215547904;
    localparam int SKY_G_RECIP = 1311;
    localparam logic [CH_W-1:0] SKY_BLUE = 16'd77;

    // Stream packing.
    localparam int IN_W        = 3 * DIR_W + FACE_W + 2 * POS_W + 3 * CH_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = FACE_W + 3 * CH_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_PAD     = OUT_TDATA_W - OUT_W;

    localparam int IN_DX_LO  = 0;
    localparam int IN_DY_LO  = IN_DX_LO + DIR_W;
    localparam int IN_DZ_LO  = IN_DY_LO + DIR_W;
    localparam int IN_TF_LO  = IN_DZ_LO + DIR_W;
    localparam int IN_TC_LO  = IN_TF_LO + FACE_W;
    localparam int IN_TR_LO  = IN_TC_LO + POS_W;
    localparam int IN_RED_LO = IN_TR_LO + POS_W;
    localparam int IN_GRN_LO = IN_RED_LO + CH_W;
    localparam int IN_BLU_LO = IN_GRN_LO + CH_W;

    typedef enum logic [FACE_W-1:0] {
        FACE_PX, FACE_NX, FACE_PY, FACE_NY, FACE_PZ, FACE_NZ
    } t_face;

    typedef struct packed {
        logic               valid;
        logic               wr;
        logic               wr_ok;
        t_face              face;
        logic [FS_W-1:0]    wr_row;
        logic [FS_W-1:0]    wr_col;
        logic [TEXEL_W-1:0] wr_data;
        logic               sky;
        logic [CH_W-1:0]    sky_r;
        logic [CH_W-1:0]    sky_g;
        logic [FS_W-1:0]    size_m1;
    } t_item;

    typedef struct packed {
        t_item            item;
        logic [NUM_W-1:0] wx;
        logic [NUM_W-1:0] wy;
        logic [DV_W-1:0]  d;
    } t_div;

endpackage

@@ design/cbs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cbs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 6144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ design/cbs_front.sv @@
// ----------------------------------------------------------------------------
// Cube map sampler front end
// Registers a request, picks the major axis and face, forms the position
// dividends and divisor, and computes the fallback sky gradient.
// ----------------------------------------------------------------------------
module cbs_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_accept,
    input  logic                             i_action,
    input  logic signed [cbs_pkg::DIR_W-1:0] i_dir_x,
    input  logic signed [cbs_pkg::DIR_W-1:0] i_dir_y,
    input  logic signed [cbs_pkg::DIR_W-1:0] i_dir_z,
    input  logic [cbs_pkg::FACE_W-1:0]       i_texel_face,
    input  logic [cbs_pkg::POS_W-1:0]        i_texel_col,
    input  logic [cbs_pkg::POS_W-1:0]        i_texel_row,
    input  logic [cbs_pkg::CH_W-1:0]         i_texel_red,
    input  logic [cbs_pkg::CH_W-1:0]         i_texel_green,
    input  logic [cbs_pkg::CH_W-1:0]         i_texel_blue,
    input  logic [cbs_pkg::CFG_W-1:0]        i_face_size,
    input  logic                             i_sky_valid,
    output cbs_pkg::t_div                    o_div
);

    import cbs_pkg::*;

    logic signed [DV_W-1:0] sx, sy, sz, sc, tc;
    logic [DV_W-1:0]        ax, ay, az, ma;
    t_face                  face;
    logic [FS_W-1:0]        size_m1;
    logic [DV_W+FS_W-1:0]   prod_x, prod_y;
    int                     sky_a, sky_b, sky_rq, sky_gq;
    logic [CH_W-1:0]        sky_ta, sky_tb;
    t_div                   n_div;
    t_div                   r_div;
    logic                   r_valid;

    // Offset sc+ma clamped to [0, 2*ma].
    function automatic logic [DV_W-1:0] pos_offset(input logic signed [DV_W-1:0] s,
                                                   input logic [DV_W-1:0] m);
        logic signed [DV_W:0] sum;
        logic signed [DV_W:0] lim;
        sum = {s[DV_W-1], s} + $signed({1'b0, m});
        lim = $signed({m, 1'b0});
        if (sum < 0) begin
            return '0;
        end else if (sum > lim) begin
            return DV_W'(lim);
        end
        return DV_W'(sum);
    endfunction

    always_comb begin
        sx = {i_dir_x[DIR_W-1], i_dir_x};
        sy = {i_dir_y[DIR_W-1], i_dir_y};
        sz = {i_dir_z[DIR_W-1], i_dir_z};
        ax = sx[DV_W-1] ? DV_W'(-sx) : DV_W'(sx);
        ay = sy[DV_W-1] ? DV_W'(-sy) : DV_W'(sy);
        az = sz[DV_W-1] ? DV_W'(-sz) : DV_W'(sz);

        if (ax >= ay && ax >= az) begin
            ma = ax;
            if (sx > 0) begin
                face = FACE_PX; sc = -sz; tc = -sy;
            end else begin
                face = FACE_NX; sc = sz;  tc = -sy;
            end
        end else if (ay >= az) begin
            ma = ay;
            if (sy > 0) begin
                face = FACE_PY; sc = sx; tc = sz;
            end else begin
                face = FACE_NY; sc = sx; tc = -sz;
            end
        end else begin
            ma = az;
            if (sz > 0) begin
                face = FACE_PZ; sc = sx;  tc = -sy;
            end else begin
                face = FACE_NZ; sc = -sx; tc = -sy;
            end
        end

        // A zero direction samples the centre of its face.
        if (ma == '0) begin
            sc = '0;
            tc = '0;
            ma = DV_W'(1);
        end

        if (i_face_size == '0) begin
            size_m1 = '0;
        end else if (int'(i_face_size) > MAX_FACE_SIZE) begin
            size_m1 = FS_W'(MAX_FACE_SIZE - 1);
        end else begin
            size_m1 = FS_W'(i_face_size - CFG_W'(1));
        end

        prod_x = pos_offset(sc, ma) * size_m1;
        prod_y = pos_offset(tc, ma) * size_m1;

        // Division by 5*2^16 and 50*2^16 as a shift and a reciprocal multiply.
        sky_a  = int'(sy) * SKY_R_MUL + SKY_R_ADD;
        sky_b  = int'(sy) * SKY_G_MUL + SKY_G_ADD;
        sky_ta = CH_W'(sky_a >>> FRAC_W);
        sky_tb = CH_W'(sky_b >>> FRAC_W);
        sky_rq = (int'(sky_ta) * SKY_R_RECIP) >>> FRAC_W;
        sky_gq = (int'(sky_tb) * SKY_G_RECIP) >>> FRAC_W;

        n_div.item.valid   = i_accept;
        n_div.item.wr      = (i_action == ACT_WRITE);
        n_div.item.wr_ok   = (int'(i_texel_face) < FACE_COUNT)
                          && (int'(i_texel_col) < MAX_FACE_SIZE)
                          && (int'(i_texel_row) < MAX_FACE_SIZE);
        n_div.item.face    = (i_action == ACT_WRITE) ? t_face'(i_texel_face) : face;
        n_div.item.wr_row  = FS_W'(i_texel_row);
        n_div.item.wr_col  = FS_W'(i_texel_col);
        n_div.item.wr_data = {i_texel_blue, i_texel_green, i_texel_red};
        n_div.item.sky     = !i_sky_valid;
        n_div.item.sky_r   = CH_W'(sky_rq);
        n_div.item.sky_g   = CH_W'(sky_gq);
        n_div.item.size_m1 = size_m1;
        n_div.wx           = {prod_x, FRAC_W'(0)};
        n_div.wy           = {prod_y, FRAC_W'(0)};
        n_div.d            = {ma[DV_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    always_comb begin
        o_div            = r_div;
        o_div.item.valid = r_valid;
    end

endmodule

@@ design/cbs_div_step.sv @@
// ----------------------------------------------------------------------------
// Divider step
// One restoring division step for both face axes; the quotient bits shift in
// at the bottom of each working word as the dividend bits shift out.
// ----------------------------------------------------------------------------
module cbs_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  cbs_pkg::t_div i_div,
    output cbs_pkg::t_div o_div
);

    import cbs_pkg::*;

    t_div n_div;
    t_div r_div;
    logic r_valid;

    function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] w,
                                                  input logic [DV_W-1:0] d);
        logic [NUM_W:0] sh;
        logic [DV_W:0]  rem;
        logic           qbit;
        sh   = {w, 1'b0};
        rem  = sh[NUM_W:QT_W];
        qbit = 1'b0;
        if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            qbit = 1'b1;
        end
        return {rem[DV_W-1:0], sh[QT_W-1:1], qbit};
    endfunction

    always_comb begin
        n_div    = i_div;
        n_div.wx = div_step(i_div.wx, i_div.d);
        n_div.wy = div_step(i_div.wy, i_div.d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_div.item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    always_comb begin
        o_div            = r_div;
        o_div.item.valid = r_valid;
    end

endmodule

@@ design/cbs_texel.sv @@
// ----------------------------------------------------------------------------
// Texel fetch and blend
// Writes texels into four banks split by row and column parity, reads the
// four neighbors of a sample in one read, and blends them bilinearly.
// ----------------------------------------------------------------------------
module cbs_texel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  cbs_pkg::t_div               i_div,
    output logic                        o_valid,
    output logic [cbs_pkg::FACE_W-1:0]  o_face,
    output logic [cbs_pkg::CH_W-1:0]    o_red,
    output logic [cbs_pkg::CH_W-1:0]    o_green,
    output logic [cbs_pkg::CH_W-1:0]    o_blue
);

    import cbs_pkg::*;

    logic [QT_W-1:0]    qx, qy;
    logic [FS_W-1:0]    x0, y0, x1, y1;
    logic [FRAC_W:0]    dx, dy, ix, iy;
    logic               same_x, same_y;
    logic [FS_W-1:0]    row_sel [BANKS];
    logic [FS_W-1:0]    col_sel [BANKS];
    logic [RAM_AW-1:0]  raddr [BANKS];
    logic [TEXEL_W-1:0] rdata [BANKS];
    logic [BANKS-1:0]   we;
    logic [RAM_AW-1:0]  waddr;
    logic [1:0]         wbank;

    // Fetch stage registers.
    logic               r_f_valid, r_f_sky, r_f_x0p, r_f_y0p, r_f_same_x, r_f_same_y;
    t_face              r_f_face;
    logic [CH_W-1:0]    r_f_sky_r, r_f_sky_g;
    logic [WGT_W-1:0]   r_f_w00, r_f_w10, r_f_w01, r_f_w11;

    // Product stage registers.
    logic               r_p_valid, r_p_sky;
    t_face              r_p_face;
    logic [CH_W-1:0]    r_p_sky_r, r_p_sky_g;
    logic [PROD_W-1:0]  r_p00 [3];
    logic [PROD_W-1:0]  r_p10 [3];
    logic [PROD_W-1:0]  r_p01 [3];
    logic [PROD_W-1:0]  r_p11 [3];
    logic [PROD_W-1:0]  n_p00 [3];
    logic [PROD_W-1:0]  n_p10 [3];
    logic [PROD_W-1:0]  n_p01 [3];
    logic [PROD_W-1:0]  n_p11 [3];
    logic [TEXEL_W-1:0] t00, t10, t01, t11;

    logic [SUM_W-1:0]   sum [3];
    logic [CH_W-1:0]    n_ch [3];

    logic               r_o_valid;
    t_face              r_o_face;
    logic [CH_W-1:0]    r_o_red, r_o_green, r_o_blue;

    assign qx     = i_div.wx[QT_W-1:0];
    assign qy     = i_div.wy[QT_W-1:0];
    assign x0     = qx[QT_W-1:FRAC_W];
    assign y0     = qy[QT_W-1:FRAC_W];
    assign dx     = {1'b0, qx[FRAC_W-1:0]};
    assign dy     = {1'b0, qy[FRAC_W-1:0]};
    assign ix     = {1'b1, FRAC_W'(0)} - dx;
    assign iy     = {1'b1, FRAC_W'(0)} - dy;
    assign same_x = (x0 == i_div.item.size_m1);
    assign same_y = (y0 == i_div.item.size_m1);
    assign x1     = same_x ? x0 : x0 + FS_W'(1);
    assign y1     = same_y ? y0 : y0 + FS_W'(1);

    assign wbank = {i_div.item.wr_row[0], i_div.item.wr_col[0]};
    assign waddr = {i_div.item.face, i_div.item.wr_row[FS_W-1:1],
                    i_div.item.wr_col[FS_W-1:1]};

    genvar b;
    generate
        for (b = 0; b < BANKS; b++) begin : g_bank
            localparam logic [1:0] BI = 2'(b);
            // Each bank holds one parity class, so the four neighbors never collide;
            // on a clamped edge the unused bank read is masked out after the read.
            assign row_sel[b] = (y0[0] == BI[1]) ? y0 : y1;
            assign col_sel[b] = (x0[0] == BI[0]) ? x0 : x1;
            assign raddr[b]   = {i_div.item.face, row_sel[b][FS_W-1:1],
                                 col_sel[b][FS_W-1:1]};
            assign we[b]      = i_en && i_div.item.valid && i_div.item.wr
                             && i_div.item.wr_ok && (wbank == BI);

            cbs_ram #(
                .WIDTH (TEXEL_W),
                .DEPTH (RAM_DEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (we[b]),
                .i_waddr (waddr),
                .i_wdata (i_div.item.wr_data),
                .i_re    (i_en),
                .i_raddr (raddr[b]),
                .o_rdata (rdata[b])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_f_valid <= i_div.item.valid && !i_div.item.wr;
            r_p_valid <= r_f_valid;
            r_o_valid <= r_p_valid;
        end
    end

    // The weights are widened before the multiply so that a full weight of 2^32 survives.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_face   <= i_div.item.face;
            r_f_sky    <= i_div.item.sky;
            r_f_sky_r  <= i_div.item.sky_r;
            r_f_sky_g  <= i_div.item.sky_g;
            r_f_x0p    <= x0[0];
            r_f_y0p    <= y0[0];
            r_f_same_x <= same_x;
            r_f_same_y <= same_y;
            r_f_w00    <= WGT_W'(ix) * WGT_W'(iy);
            r_f_w10    <= WGT_W'(dx) * WGT_W'(iy);
            r_f_w01    <= WGT_W'(ix) * WGT_W'(dy);
            r_f_w11    <= WGT_W'(dx) * WGT_W'(dy);
        end
    end

    always_comb begin
        t00 = rdata[{r_f_y0p, r_f_x0p}];
        t10 = r_f_same_x ? t00 : rdata[{r_f_y0p, ~r_f_x0p}];
        t01 = r_f_same_y ? t00 : rdata[{~r_f_y0p, r_f_x0p}];
        if (r_f_same_x) begin
            t11 = t01;
        end else if (r_f_same_y) begin
            t11 = t10;
        end else begin
            t11 = rdata[{~r_f_y0p, ~r_f_x0p}];
        end
        for (int c = 0; c < 3; c++) begin
            n_p00[c] = t00[c*CH_W +: CH_W] * r_f_w00;
            n_p10[c] = t10[c*CH_W +: CH_W] * r_f_w10;
            n_p01[c] = t01[c*CH_W +: CH_W] * r_f_w01;
            n_p11[c] = t11[c*CH_W +: CH_W] * r_f_w11;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_face  <= r_f_face;
            r_p_sky   <= r_f_sky;
            r_p_sky_r <= r_f_sky_r;
            r_p_sky_g <= r_f_sky_g;
            r_p00     <= n_p00;
            r_p10     <= n_p10;
            r_p01     <= n_p01;
            r_p11     <= n_p11;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = SUM_W'(r_p00[c]) + SUM_W'(r_p10[c]) + SUM_W'(r_p01[c])
                   + SUM_W'(r_p11[c]) + (SUM_W'(1) << (ROUND_SH - 1));
            if (|sum[c][SUM_W-1:ROUND_SH+CH_W]) begin
                n_ch[c] = '1;
            end else begin
                n_ch[c] = sum[c][ROUND_SH+CH_W-1:ROUND_SH];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_face  <= r_p_face;
            r_o_red   <= r_p_sky ? r_p_sky_r : n_ch[0];
            r_o_green <= r_p_sky ? r_p_sky_g : n_ch[1];
            r_o_blue  <= r_p_sky ? SKY_BLUE  : n_ch[2];
        end
    end

    assign o_valid = r_o_valid;
    assign o_face  = r_o_face;
    assign o_red   = r_o_red;
    assign o_green = r_o_green;
    assign o_blue  = r_o_blue;

endmodule

@@ design/cubemap_bilinear_sampler.sv @@
// ----------------------------------------------------------------------------
// Cube map bilinear sampler
// Throughput: one request per cycle while the output is not stalled; the
// 22-stage position divider and the four parity banks that fetch all
// neighbors in one read set this figure. A stalled output holds the whole
// pipeline. Reset clears all valid flags and sets face_size to 64 and
// sky_valid to 0; texel memory is not cleared.
// ----------------------------------------------------------------------------
`include "cubemap_bilinear_sampler_assert.svh"

module cubemap_bilinear_sampler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cbs_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [cbs_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // dir_x, dir_y, dir_z, texel_face, texel_col, texel_row,
    // texel_red, texel_green, texel_blue, zero pad
    input  logic [cbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // face_index, color_red, color_green, color_blue, zero pad
    output logic [cbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import cbs_pkg::*;

    logic             r_sky_valid;
    logic [CFG_W-1:0] r_face_size;
    logic             w_en;
    logic             w_accept;
    t_div             w_div [DIV_STAGES+1];
    logic             w_valid;
    logic [FACE_W-1:0] w_face;
    logic [CH_W-1:0]  w_red, w_green, w_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= FACE_SIZE_RST;
            r_sky_valid <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FACE_SIZE: r_face_size <= i_cfg_wdata;
                REG_SKY_VALID: r_sky_valid <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_en          = !w_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && w_en;
    assign s_axis_tready = w_en;

    cbs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_accept      (w_accept),
        .i_action      (s_axis_tuser),
        .i_dir_x       (s_axis_tdata[IN_DX_LO +: DIR_W]),
        .i_dir_y       (s_axis_tdata[IN_DY_LO +: DIR_W]),
        .i_dir_z       (s_axis_tdata[IN_DZ_LO +: DIR_W]),
        .i_texel_face  (s_axis_tdata[IN_TF_LO +: FACE_W]),
        .i_texel_col   (s_axis_tdata[IN_TC_LO +: POS_W]),
        .i_texel_row   (s_axis_tdata[IN_TR_LO +: POS_W]),
        .i_texel_red   (s_axis_tdata[IN_RED_LO +: CH_W]),
        .i_texel_green (s_axis_tdata[IN_GRN_LO +: CH_W]),
        .i_texel_blue  (s_axis_tdata[IN_BLU_LO +: CH_W]),
        .i_face_size   (r_face_size),
        .i_sky_valid   (r_sky_valid),
        .o_div         (w_div[0])
    );

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_div
            cbs_div_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_div   (w_div[k]),
                .o_div   (w_div[k+1])
            );
        end
    endgenerate

    cbs_texel u_texel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_div   (w_div[DIV_STAGES]),
        .o_valid (w_valid),
        .o_face  (w_face),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    assign m_axis_tvalid = w_valid;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, w_blue, w_green, w_red, w_face};

    // The divider only works if the first partial remainder is below the divisor.
    `CBS_ASSERT_NOW(a_div_init, w_div[0].item.valid, w_div[0].wx[NUM_W-1:QT_W] < w_div[0].d && w_div[0].wy[NUM_W-1:QT_W] < w_div[0].d, "divider start remainder not below divisor")
    `CBS_ASSERT_NOW(a_div_range, w_div[DIV_STAGES].item.valid && !w_div[DIV_STAGES].item.wr, w_div[DIV_STAGES].wx[QT_W-1:FRAC_W] <= w_div[DIV_STAGES].item.size_m1 && w_div[DIV_STAGES].wy[QT_W-1:FRAC_W] <= w_div[DIV_STAGES].item.size_m1, "texel position beyond face edge")
    `CBS_ASSERT_NEXT(a_stall_hold, !w_en, $stable(w_div[DIV_STAGES]), "pipeline moved during output stall")

endmodule

@@ sim/cbs_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cube map sampler checker
// Watches the configuration port and both streams, keeps its own copy of the
// texel map and registers, predicts each sample result and compares in order.
// ----------------------------------------------------------------------------
module cbs_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cbs_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [cbs_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [cbs_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [cbs_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);

    import cbs_pkg::*;

    typedef struct {
        t_face       face;
        logic [15:0] red;
        logic [15:0] grn;
        logic [15:0] blu;
    } t_color;

    localparam int DEPTH = FACE_COUNT * MAX_FACE_SIZE * MAX_FACE_SIZE;

    logic [TEXEL_W-1:0] texels [0:DEPTH-1];
    logic [CFG_W-1:0]   face_size_q;
    logic               sky_valid_q;
    t_color             color_queue [$];

    assign o_pending = color_queue.size();

    function automatic longint face_coord(longint sc, longint ma, longint size);
        longint n;
        if (ma <= 0) begin
            sc = 0;
            ma = 1;
        end
        n = sc + ma;
        if (n < 0) n = 0;
        if (n > 2 * ma) n = 2 * ma;
        return (n * (size - 1) * 65536) / (2 * ma);
    endfunction

    function automatic logic [15:0] mix_channel(int ch, int i00, int i10, int i01,
                                                int i11, longint fx, longint fy);
        longint gx, gy, s;
        gx = 65536 - fx;
        gy = 65536 - fy;
        s = longint'(texels[i00][ch*16 +: 16]) * (gx * gy)
          + longint'(texels[i10][ch*16 +: 16]) * (fx * gy)
          + longint'(texels[i01][ch*16 +: 16]) * (gx * fy)
          + longint'(texels[i11][ch*16 +: 16]) * (fx * fy);
        s = (s + 64'h8000_0000) >>> 32;
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic t_color sample_color(logic signed [15:0] dx, logic signed [15:0] dy,
                                            logic signed [15:0] dz);
        t_color c;
        longint x, y, z, ax, ay, az, ma, sc, tc, size, px, py, rr, gg;
        int x0, y0, x1, y1, base;
        x = dx; y = dy; z = dz;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        if (ax >= ay && ax >= az) begin
            ma = ax;
            if (x > 0) begin c.face = FACE_PX; sc = -z; tc = -y; end
            else begin c.face = FACE_NX; sc = z; tc = -y; end
        end else if (ay >= az) begin
            ma = ay;
            if (y > 0) begin c.face = FACE_PY; sc = x; tc = z; end
            else begin c.face = FACE_NY; sc = x; tc = -z; end
        end else begin
            ma = az;
            if (z > 0) begin c.face = FACE_PZ; sc = x; tc = -y; end
            else begin c.face = FACE_NZ; sc = -x; tc = -y; end
        end
        if (!sky_valid_q) begin
            rr = (384 * (y + 49152) + 163840) / 327680;
            gg = (5376 * 32768 + 2304 * (y + 32768) - 2304 * 16384 + 1638400) / 3276800;
            c.red = (rr > 65535) ? 16'hFFFF : rr[15:0];
            c.grn = (gg > 65535) ? 16'hFFFF : gg[15:0];
            c.blu = 16'd77;
            return c;
        end
        size = face_size_q;
        if (size < 1) size = 1;
        if (size > MAX_FACE_SIZE) size = MAX_FACE_SIZE;
        px = face_coord(sc, ma, size);
        py = face_coord(tc, ma, size);
        x0 = int'(px >>> 16);
        y0 = int'(py >>> 16);
        if (x0 > size - 1) x0 = size - 1;
        if (y0 > size - 1) y0 = size - 1;
        x1 = (x0 + 1 < size) ? x0 + 1 : size - 1;
        y1 = (y0 + 1 < size) ? y0 + 1 : size - 1;
        base = int'(c.face) * MAX_FACE_SIZE * MAX_FACE_SIZE;
        for (int ch = 0; ch < 3; ch++) begin
            logic [15:0] v;
            v = mix_channel(ch, base + y0 * MAX_FACE_SIZE + x0, base + y0 * MAX_FACE_SIZE + x1,
                            base + y1 * MAX_FACE_SIZE + x0, base + y1 * MAX_FACE_SIZE + x1,
                            px & 65535, py & 65535);
            if (ch == 0) c.red = v;
            else if (ch == 1) c.grn = v;
            else c.blu = v;
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_color exp_c, got;
        logic [2:0] tf;
        logic [5:0] tcol, trow;
        if (!i_rst_n) begin
            face_size_q <= FACE_SIZE_RST;
            sky_valid_q <= 1'b0;
            color_queue.delete();
            o_fail_count <= 0;
            o_checked <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_FACE_SIZE) face_size_q <= i_cfg_wdata;
                else if (i_cfg_addr == REG_SKY_VALID) sky_valid_q <= i_cfg_wdata[0];
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == ACT_SAMPLE) begin
                    color_queue.push_back(sample_color(i_s_tdata[IN_DX_LO +: DIR_W],
                                                       i_s_tdata[IN_DY_LO +: DIR_W],
                                                       i_s_tdata[IN_DZ_LO +: DIR_W]));
                end else begin
                    tf = i_s_tdata[IN_TF_LO +: FACE_W];
                    tcol = i_s_tdata[IN_TC_LO +: POS_W];
                    trow = i_s_tdata[IN_TR_LO +: POS_W];
                    // Faces past the last one are dropped by the block.
                    if (tf < FACE_COUNT)
                        texels[(int'(tf) * MAX_FACE_SIZE + trow) * MAX_FACE_SIZE + tcol] =
                            i_s_tdata[IN_RED_LO +: TEXEL_W];
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.face = t_face'(i_m_tdata[0 +: FACE_W]);
                got.red = i_m_tdata[FACE_W +: CH_W];
                got.grn = i_m_tdata[FACE_W + CH_W +: CH_W];
                got.blu = i_m_tdata[FACE_W + 2 * CH_W +: CH_W];
                if (color_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result face=%0d rgb=%h %h %h",
                                 got.face, got.red, got.grn, got.blu);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_c = color_queue.pop_front();
                    o_checked <= o_checked + 1;
                    if (got.face !== exp_c.face || got.red !== exp_c.red ||
                        got.grn !== exp_c.grn || got.blu !== exp_c.blu) begin
                        if (o_fail_count < 10)
                            $display("ERROR: sample %0d face %0d/%0d rgb %h %h %h / %h %h %h",
                                     o_checked, exp_c.face, got.face, exp_c.red, exp_c.grn,
                                     exp_c.blu, got.red, got.grn, got.blu);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb_cubemap_bilinear_sampler.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cube map sampler testbench
// Drives texel writes and sample requests with random gaps on both streams
// across several face sizes and both sky modes; a checker predicts results.
// ----------------------------------------------------------------------------
module tb_cubemap_bilinear_sampler;
    import cbs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]      i_cfg_addr = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count, pending, checked;
    int cycles = 0;
    int requests = 0;
    bit steady = 0;
    bit big_face;

    cubemap_bilinear_sampler dut (.*);

    cbs_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata), .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser), .i_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata), .o_fail_count(fail_count),
        .o_pending(pending), .o_checked(checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stalls before each result, none in steady phases.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = steady ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk iff (m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic send(logic act, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                        logic [2:0] f, logic [5:0] c, logic [5:0] r, logic [47:0] rgb);
        int n;
        n = steady ? 0 : $urandom_range(0, 8);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {{(IN_TDATA_W - IN_W){1'b0}}, rgb, r, c, f, z, y, x};
        @(posedge i_clk iff (s_axis_tvalid && s_axis_tready));
        requests++;
    endtask

    task automatic texel_write(logic [2:0] f, logic [5:0] c, logic [5:0] r);
        send(ACT_WRITE, 16'($urandom), 16'($urandom), 16'($urandom), f, c, r,
             48'({$urandom, $urandom}));
    endtask

    task automatic sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        send(ACT_SAMPLE, x, y, z, 3'($urandom), 6'($urandom), 6'($urandom),
             48'({$urandom, $urandom}));
    endtask

    // Let every result drain; writes leave no result, so allow the pipeline depth too.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk iff (pending == 0));
        repeat (32) @(posedge i_clk);
    endtask

    // The write enable drops again after each write so that back-to-back writes stay apart.
    task automatic reg_write(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // A direction near a face centre; only the central texel block is known there.
    task automatic centered_sample();
        int ma, lim, a, b, axis;
        ma = $urandom_range(4096, 16384);
        lim = ma / 90;
        a = $urandom_range(0, 2 * lim) - lim;
        b = $urandom_range(0, 2 * lim) - lim;
        if ($urandom_range(0, 1)) ma = -ma;
        axis = $urandom_range(0, 2);
        if (axis == 0) sample(16'(ma), 16'(a), 16'(b));
        else if (axis == 1) sample(16'(a), 16'(ma), 16'(b));
        else sample(16'(a), 16'(b), 16'(ma));
    endtask

    task automatic random_dir_sample();
        int lo;
        lo = $urandom_range(0, 1) ? -16384 : -32768;
        if (lo == -32768) sample(16'($urandom), 16'($urandom), 16'($urandom));
        else sample(16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384));
    endtask

    initial begin
        int sizes [9];
        bit skies [9];
        int eff;
        sizes = '{1, 2, 3, 8, 0, 64, 127, 5, 64};
        skies = '{1, 1, 1, 1, 1, 1, 1, 0, 0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: sky gradient at reset settings, axis extremes, ties, zero.
        sample(0, 0, 0);
        sample(16384, 0, 0);
        sample(-16384, 0, 0);
        sample(0, 16384, 0);
        sample(0, -16384, 0);
        sample(0, 0, 16384);
        sample(0, 0, -16384);
        sample(16384, 16384, 16384);
        sample(-16384, -16384, -16384);
        sample(0, 9000, -9000);
        sample(16'h8000, 16'h8000, 16'h7FFF);
        sample(16'h7FFF, 16'h8000, 0);
        send(ACT_WRITE, 0, 0, 0, 3'd6, 6'd63, 6'd63, 48'hFFFF_FFFF_FFFF);
        send(ACT_WRITE, 0, 0, 0, 3'd7, 6'd0, 6'd0, '0);

        // Fill the 8x8 corner of every face and a 4x4 block at the face centers.
        steady = 1;
        for (int f = 0; f < FACE_COUNT; f++) begin
            for (int r = 0; r < 8; r++)
                for (int c = 0; c < 8; c++) texel_write(3'(f), 6'(c), 6'(r));
            for (int r = 30; r < 34; r++)
                for (int c = 30; c < 34; c++) texel_write(3'(f), 6'(c), 6'(r));
        end
        texel_write(3'd0, 6'd0, 6'd0);
        drain();

        for (int p = 0; p < 9; p++) begin
            reg_write(REG_FACE_SIZE, CFG_W'(sizes[p]));
            reg_write(REG_SKY_VALID, CFG_W'(skies[p]));
            eff = (sizes[p] == 0) ? 1 : sizes[p];
            big_face = (eff > 8) && skies[p];
            steady = (p % 3 == 2);
            if (skies[p] && !big_face) begin
                sample(0, 0, 0);
                sample(16384, -16384, 0);
                sample(0, 0, -16384);
            end
            for (int i = 0; i < 110; i++) begin
                if ($urandom_range(0, 4) == 0)
                    texel_write(3'($urandom_range(0, 7)), 6'($urandom), 6'($urandom));
                else if (big_face || $urandom_range(0, 3) == 0)
                    centered_sample();
                else
                    random_dir_sample();
            end
            drain();
        end

        $display("Covered %0d requests, %0d results checked, face sizes 0 to 127,",
                 requests, checked);
        $display("stored map and sky gradient modes, with stalls on both streams.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
